@@ design/fqd_pkg.sv @@
package fqd_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int ITEM_W  = 32;
  localparam int OUT_W   = 32;
  localparam int LEN_W   = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_LENGTH  = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic compare;
    logic apply;
  } ctrl_t;

endpackage

@@ design/fqd_in_if.sv @@
interface fqd_in_if;
  import fqd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ITEM_W-1:0]   item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink   (input valid, input command, input item_value, output ready);
endinterface

@@ design/fqd_out_if.sv @@
interface fqd_out_if;
  import fqd_pkg::*;

  logic               valid;
  logic               ready;
  logic               failed;
  logic [OUT_W-1:0]   out_value;
  logic [LEN_W-1:0]   length;

  modport source (output valid, output failed, output out_value, output length, input ready);
  modport sink   (input valid, input failed, input out_value, input length, output ready);
endinterface

@@ design/fqd_ctrl.sv @@
module fqd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output fqd_pkg::ctrl_t ctrl
);
  import fqd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = S_MATCH;
        end
      end
      S_MATCH: begin
        ctrl.compare = 1'b1;
        state_next   = S_APPLY;
      end
      S_APPLY: begin
        // Wait until the result register is free or being emptied.
        if (!out_valid || out_ready) begin
          ctrl.apply = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl.apply) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/fqd_datapath.sv @@
module fqd_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  fqd_pkg::ctrl_t            ctrl,
  input  logic [fqd_pkg::CMD_W-1:0]  command,
  input  logic [fqd_pkg::ITEM_W-1:0] item_value,
  output logic                      failed,
  output logic [fqd_pkg::OUT_W-1:0]  out_value,
  output logic [fqd_pkg::LEN_W-1:0]  length
);
  import fqd_pkg::*;

  logic [VALUE_WIDTH-1:0] entries [DEPTH];
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;

  cmd_t                   cmd_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [DEPTH-1:0]       match_r;

  logic [DEPTH-1:0]       first;
  logic [DEPTH-1:0]       shift_mask;
  logic                   val_nz;
  logic                   enq_ok;
  logic                   deq_ok;
  logic                   del_ok;
  logic                   shift_en;
  logic                   fail_now;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= cmd_t'(command);
      val_r <= item_value[VALUE_WIDTH-1:0];
    end
  end

  // Every live cell compares against the operand at once; the match vector is registered.
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i] <= (entries[i] == val_r) && (count > CNT_W'(i));
      end
    end
  end

  assign val_nz = (val_r != '0);
  assign first  = match_r & (~match_r + DEPTH'(1));

  always_comb begin
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    del_ok     = 1'b0;
    shift_mask = '1;
    case (cmd_r)
      CMD_ENQUEUE: enq_ok = val_nz && (count < CNT_W'(DEPTH));
      CMD_DEQUEUE: deq_ok = (count != '0);
      CMD_DELETE: begin
        del_ok     = val_nz && (match_r != '0);
        shift_mask = ~(first - DEPTH'(1));
      end
      CMD_LENGTH: ;
      default: ;
    endcase
  end

  assign shift_en = deq_ok || del_ok;
  assign fail_now = ((cmd_r == CMD_ENQUEUE) && !enq_ok)
                 || ((cmd_r == CMD_DEQUEUE) && !deq_ok)
                 || ((cmd_r == CMD_DELETE) && !del_ok);

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + CNT_W'(1);
    end else if (shift_en) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctrl.apply) begin
        if (g < DEPTH - 1 && shift_en && shift_mask[g]) begin
          entries[g] <= entries[(g + 1) % DEPTH];
        end else if (enq_ok && count == CNT_W'(g)) begin
          entries[g] <= val_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      failed    <= fail_now;
      out_value <= deq_ok ? OUT_W'(entries[0]) : '0;
      length    <= LEN_W'(count_next);
    end
  end

endmodule

@@ design/fifo_queue_with_delete.sv @@
// Bounded first-in first-out queue of nonzero value tokens, up to 16 entries
// deep, with enqueue, dequeue, delete by value and read length commands.
// Commands arrive on in_ch as a command code and a value; each accepted
// transfer gives exactly one result transfer on out_ch carrying a failure
// flag, the dequeued value (zero otherwise) and the length after the command.
// An input transfer is taken only while the block is idle. The command is
// registered when it is taken, every stored entry is then compared with the
// value, and a last step updates the entry chain and loads the result
// register. A new command is taken only once the previous one has gone
// through all three steps of the controller sequence.
// The result register parts the two sides: the next command is accepted and
// compared while an earlier result still waits. If the receiver stalls, the
// block holds the finished command in its last step until the result register
// empties, and stops accepting input.
// Synchronous reset empties the queue and drops any pending result; stored
// entry values are not cleared, as only slots below the count are ever read.
module fifo_queue_with_delete (
  input logic       clk,
  input logic       rst,
  fqd_in_if.sink    in_ch,
  fqd_out_if.source out_ch
);
  import fqd_pkg::*;

  ctrl_t ctrl;

  // The controller sequences each command and owns both handshakes.
  fqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  // The datapath holds the entry chain, the count and the result register.
  fqd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .command    (in_ch.command),
    .item_value (in_ch.item_value),
    .failed     (out_ch.failed),
    .out_value  (out_ch.out_value),
    .length     (out_ch.length)
  );

endmodule

@@ design/fqd_checker.sv @@
module fqd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      failed,
  input logic [fqd_pkg::OUT_W-1:0] out_value,
  input logic [fqd_pkg::LEN_W-1:0] length
);
  import fqd_pkg::*;

  // The queue never reports more entries than it can hold.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length <= LEN_W'(DEPTH)))
    else $error("length above depth");

  // A failed command never returns a value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && failed) |-> (out_value == '0))
    else $error("failed result carries a value");

  // After an input transfer the block is busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // A result appears only after a command was taken.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid || $past(out_valid))
    else $error("result appeared one cycle after input");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(failed)
      && $stable(out_value) && $stable(length))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .failed    (out_ch.failed),
  .out_value (out_ch.out_value),
  .length    (out_ch.length)
);

@@ sim/tb_fifo_queue_with_delete.sv @@
module tb_fifo_queue_with_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import fqd_pkg::*;

  // A run is declared hung once this many cycles go by with no transfer on
  // either channel. The slowest correct stretch is a long receiver stall
  // behind a long sender gap plus the command sequence, so this leaves a
  // wide margin.
  localparam int IDLE_LIMIT   = 4000;
  // Cycles to keep watching the result channel after the last expected
  // result, to catch any stray extra result.
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;

  // One result transfer, field for field as the output channel carries it.
  typedef struct packed {
    logic             failed;
    logic [OUT_W-1:0] out_value;
    logic [LEN_W-1:0] length;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fqd_in_if  in_ch ();
  fqd_out_if out_ch ();

  fifo_queue_with_delete dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the queue contents, oldest entry at index 0. The block
  // keeps at most DEPTH entries; the predictor enforces the same bound.
  logic [ITEM_W-1:0] held_values[$];
  // Results predicted for accepted commands, oldest first.
  outcome_t          pending_results[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int stall_left     = 0;
  // When set, neither side inserts bubbles, so the block runs at full rate.
  bit free_flow      = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one command to the shadow queue and return the result the block
  // must give for it. Every command gives exactly one result, and the length
  // field always reports the count after the command took effect.
  function automatic outcome_t queue_outcome(cmd_t cmd, logic [ITEM_W-1:0] value);
    outcome_t res;
    bit       found;
    res   = '0;
    found = 1'b0;
    case (cmd)
      CMD_ENQUEUE: begin
        // A zero token is never stored, and a full queue refuses new entries.
        if (value == '0 || held_values.size() >= DEPTH) begin
          res.failed = 1'b1;
        end else begin
          held_values.push_back(value);
        end
      end
      CMD_DEQUEUE: begin
        // The value field stays zero when there is nothing to remove.
        if (held_values.size() == 0) begin
          res.failed = 1'b1;
        end else begin
          res.out_value = held_values.pop_front();
        end
      end
      CMD_DELETE: begin
        // Only the match nearest the head goes; the rest keep their order.
        if (value != '0) begin
          for (int i = 0; i < held_values.size() && !found; i++) begin
            if (held_values[i] == value) begin
              held_values.delete(i);
              found = 1'b1;
            end
          end
        end
        res.failed = !found;
      end
      default: begin
        // Reading the length changes nothing and never fails.
      end
    endcase
    res.length = LEN_W'(held_values.size());
    return res;
  endfunction

  // Most gaps are zero or a few cycles, now and then a long one.
  function automatic int sender_gap();
    int r;
    if (free_flow) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Token values lean toward a small set so that duplicates and delete
  // matches are common, with full-width random values so every bit of the
  // field toggles, plus zero and the extremes.
  function automatic logic [ITEM_W-1:0] random_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      return '0;
    end
    if (r < 22) begin
      return $urandom;
    end
    if (r < 26) begin
      return '1;
    end
    if (r < 29) begin
      return {1'b1, {(ITEM_W-1){1'b0}}};
    end
    return $urandom_range(1, 6);
  endfunction

  // A delete aims at a value the queue really holds about half of the time,
  // so entries deep in the chain are removed and the gap closing is exercised.
  function automatic logic [ITEM_W-1:0] delete_target();
    if (held_values.size() > 0 && $urandom_range(99) < 55) begin
      return held_values[$urandom_range(held_values.size() - 1)];
    end
    return random_value();
  endfunction

  function automatic cmd_t random_cmd(int enq_pct, int deq_pct, int del_pct);
    int r;
    r = $urandom_range(99);
    if (r < enq_pct) begin
      return CMD_ENQUEUE;
    end
    if (r < enq_pct + deq_pct) begin
      return CMD_DEQUEUE;
    end
    if (r < enq_pct + deq_pct + del_pct) begin
      return CMD_DELETE;
    end
    return CMD_LENGTH;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
    end
  endtask

  // Send one command. The task is entered and left at a falling edge. On
  // the way out valid is left high, so a back-to-back command simply
  // overwrites the payload without a one-cycle dip; a gap lowers valid once.
  // The prediction is made at the edge where the transfer happens, which
  // keeps the expected results in the order the block accepted them.
  task automatic send_cmd(cmd_t cmd, logic [ITEM_W-1:0] value);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.item_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(queue_outcome(cmd, value));
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back. Also
  // entered and left at a falling edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: ready changes only at the falling edge. A stall is started at
  // random when the previous one ends; most are short, a few are long.
  always @(negedge clk) begin
    int r;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (free_flow) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(99);
      if (r < 22) begin
        stall_left = $urandom_range(1, 3);
      end else if (r < 25) begin
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest
  // prediction, one field at a time. Case inequality makes an unknown
  // output count as a mismatch.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: failed %0b value %08h length %0d",
                                  out_ch.failed, out_ch.out_value, out_ch.length));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.failed !== want.failed) begin
          report_mismatch($sformatf("failed: expected %0b, got %0b",
                                    want.failed, out_ch.failed));
        end
        if (out_ch.out_value !== want.out_value) begin
          report_mismatch($sformatf("out_value: expected %08h, got %08h",
                                    want.out_value, out_ch.out_value));
        end
        if (out_ch.length !== want.length) begin
          report_mismatch($sformatf("length: expected %0d, got %0d",
                                    want.length, out_ch.length));
        end
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Every failing command on an empty queue: dequeue, delete of a value,
  // delete of zero, enqueue of zero, and the length read that never fails.
  task automatic test_empty_queue();
    send_cmd(CMD_DEQUEUE, 32'h0000_0005);
    send_cmd(CMD_DELETE, 32'h0000_0005);
    send_cmd(CMD_DELETE, '0);
    send_cmd(CMD_ENQUEUE, '0);
    send_cmd(CMD_LENGTH, '1);
  endtask

  // Extreme values, duplicate entries and order keeping. The all-ones value
  // is stored twice so that the delete must take the copy nearest the head,
  // after which the dequeues show which one was left behind.
  task automatic test_values_and_order();
    send_cmd(CMD_ENQUEUE, '1);
    send_cmd(CMD_ENQUEUE, 32'h0000_0001);
    send_cmd(CMD_ENQUEUE, '1);
    send_cmd(CMD_ENQUEUE, 32'h8000_0000);
    send_cmd(CMD_DELETE, '1);
    send_cmd(CMD_DELETE, 32'h0000_0007);
    send_cmd(CMD_DELETE, '0);
    send_cmd(CMD_DEQUEUE, '0);
    send_cmd(CMD_DEQUEUE, '0);
    send_cmd(CMD_DEQUEUE, '0);
    send_cmd(CMD_DEQUEUE, '0);
  endtask

  // Fill the queue to DEPTH, then check that an enqueue is refused, that a
  // delete from the middle frees exactly one slot, and that the queue is
  // full again after one more enqueue.
  task automatic test_full_queue();
    logic [ITEM_W-1:0] value;
    wait_drained();
    while (held_values.size() < DEPTH) begin
      value = $urandom;
      if (value == '0) begin
        value = 32'h0000_0001;
      end
      send_cmd(CMD_ENQUEUE, value);
    end
    send_cmd(CMD_ENQUEUE, 32'h0000_0009);
    send_cmd(CMD_DELETE, held_values[DEPTH/2]);
    send_cmd(CMD_ENQUEUE, 32'h5A5A_A5A5);
    send_cmd(CMD_ENQUEUE, 32'h0000_0003);
  endtask

  // Random traffic in phases that push the fill level up or down or keep it
  // roughly level, so the queue swings between empty and full many times. Two
  // phases run with no bubbles on either side, and in the middle the sender
  // waits for every outstanding result before going on.
  task automatic test_random_traffic();
    cmd_t              cmd;
    logic [ITEM_W-1:0] value;
    for (int phase = 0; phase < 9; phase++) begin
      free_flow = (phase == 2 || phase == 6);
      if (phase == 4) begin
        wait_drained();
      end
      for (int n = 0; n < 100; n++) begin
        case (phase % 3)
          0: cmd = random_cmd(10, 45, 35);
          1: cmd = random_cmd(60, 15, 15);
          default: cmd = random_cmd(35, 25, 30);
        endcase
        value = (cmd == CMD_DELETE) ? delete_target() : random_value();
        send_cmd(cmd, value);
      end
    end
    free_flow = 1'b0;
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_LENGTH;
    in_ch.item_value = '0;
    out_ch.ready     = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_values_and_order();
    test_full_queue();
    test_random_traffic();

    // Let the last results come home, then keep watching a little longer so
    // that an extra result would still be caught.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fqd_pkg.sv
design/fqd_in_if.sv
design/fqd_out_if.sv
design/fqd_ctrl.sv
design/fqd_datapath.sv
design/fifo_queue_with_delete.sv
design/fqd_checker.sv
sim/tb_fifo_queue_with_delete.sv
